/* rtl/core/range_flow_frame_parser_assert.svh */
// assertion macros shared by the frame parser modules
// each use expects signals named clk and rst in the enclosing module
`ifndef RANGE_FLOW_FRAME_PARSER_ASSERT_SVH
`define RANGE_FLOW_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define RFFP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rffp assertion failed");
`define RFFP_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("rffp assertion failed");
`else
`define RFFP_ASSERT_ALWAYS(lbl, expr)
`define RFFP_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

/* rtl/core/rffp_pkg.sv */
`default_nettype none
package rffp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int QUEUE_DEPTH = 4;

  // payload bytes that feed the decoded result fields (bytes 0 to 17)
  localparam int FIELD_BYTES = 18;
  localparam int IDX_W = $clog2(FIELD_BYTES);

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_BYTE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MSG_ID = 8'd1;

  localparam logic [7:0] HEADER_BYTE_RESET = 8'd239;
  localparam logic [7:0] RANGE_MSG_ID_RESET = 8'd81;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic             frame_ok;
    logic             is_range;
    logic [7:0]       msg_id;
  } op_t;

endpackage
`default_nettype wire

/* rtl/core/rffp_front.sv */
`default_nettype none
`include "range_flow_frame_parser_assert.svh"
module rffp_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             rx_valid,
  output logic                                  rx_ready,
  input  wire logic [7:0]                       rx_byte,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rffp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data,
  input  wire logic                             q_full,
  output logic                                  push,
  output rffp_pkg::op_t                         push_op
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_DEV = 3'd1;
  localparam logic [2:0] PH_SYS = 3'd2;
  localparam logic [2:0] PH_MSG = 3'd3;
  localparam logic [2:0] PH_SEQ = 3'd4;
  localparam logic [2:0] PH_LEN = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_CHECK = 3'd7;

  logic [7:0] header_byte;
  logic [7:0] range_message_id;
  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] msg_id;
  logic [7:0] msg_id_next;
  logic [7:0] frame_length;
  logic [7:0] frame_length_next;
  logic [7:0] payload_count;
  logic [7:0] payload_count_next;
  logic [8:0] count_inc;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign rx_ready = !q_full;
  assign accept = rx_valid && rx_ready;
  assign count_inc = {1'b0, payload_count} + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= rffp_pkg::HEADER_BYTE_RESET;
      range_message_id <= rffp_pkg::RANGE_MSG_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rffp_pkg::REG_HEADER_BYTE: header_byte <= cfg_data;
        rffp_pkg::REG_RANGE_MSG_ID: range_message_id <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    running_sum_next = running_sum + rx_byte;
    msg_id_next = msg_id;
    frame_length_next = frame_length;
    payload_count_next = payload_count;
    push = 1'b0;
    push_op.kind = rffp_pkg::OP_STORE;
    push_op.idx = payload_count[rffp_pkg::IDX_W-1:0];
    push_op.data = rx_byte;
    push_op.frame_ok = (rx_byte == running_sum);
    push_op.is_range = (msg_id == range_message_id);
    push_op.msg_id = msg_id;
    case (phase)
      PH_HUNT: begin
        running_sum_next = rx_byte;
        if (rx_byte == header_byte) begin
          phase_next = PH_DEV;
        end
      end
      PH_DEV, PH_SYS, PH_SEQ: begin
        phase_next = phase + 3'd1;
      end
      PH_MSG: begin
        msg_id_next = rx_byte;
        phase_next = PH_SEQ;
      end
      PH_LEN: begin
        frame_length_next = rx_byte;
        payload_count_next = '0;
        if (rx_byte == 8'd0) begin
          phase_next = PH_CHECK;
        end else if ({24'd0, rx_byte} > 32'(rffp_pkg::MAX_PAYLOAD)) begin
          phase_next = PH_HUNT;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        // only bytes that feed a result field reach the store
        push = accept && ({1'b0, payload_count} < 9'(rffp_pkg::FIELD_BYTES));
        payload_count_next = count_inc[7:0];
        if (count_inc >= {1'b0, frame_length}) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        push = accept;
        push_op.kind = rffp_pkg::OP_FINISH;
        payload_count_next = '0;
        phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      running_sum <= '0;
      msg_id <= '0;
      frame_length <= '0;
      payload_count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      running_sum <= running_sum_next;
      msg_id <= msg_id_next;
      frame_length <= frame_length_next;
      payload_count <= payload_count_next;
    end
  end

  `RFFP_ASSERT_ALWAYS(a_payload_in_frame,
    (phase != PH_PAYLOAD) || (payload_count < frame_length))
  `RFFP_ASSERT_ALWAYS(a_payload_len_legal,
    (phase != PH_PAYLOAD) || ((frame_length != 8'd0) &&
    ({24'd0, frame_length} <= 32'(rffp_pkg::MAX_PAYLOAD))))

endmodule
`default_nettype wire

/* rtl/core/rffp_queue.sv */
`default_nettype none
`include "range_flow_frame_parser_assert.svh"
module rffp_queue #(
  parameter int DEPTH = rffp_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rffp_pkg::op_t push_op,
  output logic               full,
  input  wire logic          pop,
  output rffp_pkg::op_t      pop_op,
  output logic               nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rffp_pkg::op_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RFFP_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH))
  `RFFP_ASSERT_NEXT(a_count_grows, push && !pop,
    count == CNT_W'($past(count) + 1'b1))

endmodule
`default_nettype wire

/* rtl/core/rffp_back.sv */
`default_nettype none
`include "range_flow_frame_parser_assert.svh"
module rffp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_nonempty,
  input  wire rffp_pkg::op_t q_op,
  output logic               pop,
  output logic               res_valid,
  input  wire logic          res_ready,
  output logic               frame_ok,
  output logic               is_range_report,
  output logic [7:0]         message_id,
  output logic [31:0]        time_stamp_ms,
  output logic [31:0]        range_mm,
  output logic [7:0]         tof_signal,
  output logic [7:0]         tof_accuracy,
  output logic [7:0]         tof_state,
  output logic signed [15:0] flow_speed_x,
  output logic signed [15:0] flow_speed_y,
  output logic [7:0]         flow_confidence,
  output logic [7:0]         flow_state
);

  logic [7:0] store [rffp_pkg::FIELD_BYTES];
  logic       finish;

  // a result waits for the output register, store writes never wait
  assign pop = q_nonempty &&
               ((q_op.kind == rffp_pkg::OP_STORE) || !res_valid || res_ready);
  assign finish = pop && (q_op.kind == rffp_pkg::OP_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rffp_pkg::FIELD_BYTES; i++) begin
        store[i] <= '0;
      end
    end else if (pop && (q_op.kind == rffp_pkg::OP_STORE)) begin
      store[q_op.idx] <= q_op.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      frame_ok <= q_op.frame_ok;
      is_range_report <= q_op.is_range;
      message_id <= q_op.msg_id;
      time_stamp_ms <= {store[3], store[2], store[1], store[0]};
      range_mm <= {store[7], store[6], store[5], store[4]};
      tof_signal <= store[8];
      tof_accuracy <= store[9];
      tof_state <= store[10];
      flow_speed_x <= {store[13], store[12]};
      flow_speed_y <= {store[15], store[14]};
      flow_confidence <= store[16];
      flow_state <= store[17];
    end
  end

  `RFFP_ASSERT_NEXT(a_finish_shows, finish, res_valid)

endmodule
`default_nettype wire

/* rtl/core/range_flow_frame_parser.sv */
// Byte stream frame parser for range and flow reports.
// rx channel: one received byte per transfer (rx_valid/rx_ready/rx_byte).
// cfg channel: register writes, index 0 header byte, index 1 range message id;
//   cfg_ready is always high, unknown indexes are ignored.
// res channel: one result per frame of legal length, on its checksum byte, with
//   checksum verdict, range-id match and payload fields decoded little endian.
// The front end runs the frame state machine and takes one byte every cycle
// while the op queue has room; the back end writes payload bytes into the
// field store and loads the output register on a finished frame.
// The finish op of the checksum byte passes through the op queue, then the back
//   end loads the output register and raises res_valid.
// Throughput: 1 byte per cycle while the queue has room, frames with no gap.
// A stalled result blocks only the back end; bytes keep flowing into the
// queue until it holds QUEUE_DEPTH ops, then rx_ready drops.
// Reset: header byte 239, range id 81, parser hunting, field store zero.
`default_nettype none
module range_flow_frame_parser #(
  parameter int QUEUE_DEPTH = rffp_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             rx_valid,
  output logic                                  rx_ready,
  input  wire logic [7:0]                       rx_byte,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rffp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output logic                                  frame_ok,
  output logic                                  is_range_report,
  output logic [7:0]                            message_id,
  output logic [31:0]                           time_stamp_ms,
  output logic [31:0]                           range_mm,
  output logic [7:0]                            tof_signal,
  output logic [7:0]                            tof_accuracy,
  output logic [7:0]                            tof_state,
  output logic signed [15:0]                    flow_speed_x,
  output logic signed [15:0]                    flow_speed_y,
  output logic [7:0]                            flow_confidence,
  output logic [7:0]                            flow_state
);

  logic          q_full;
  logic          q_nonempty;
  logic          push;
  logic          pop;
  rffp_pkg::op_t push_op;
  rffp_pkg::op_t pop_op;

  rffp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  rffp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (push_op),
    .full     (q_full),
    .pop      (pop),
    .pop_op   (pop_op),
    .nonempty (q_nonempty)
  );

  rffp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_nonempty      (q_nonempty),
    .q_op            (pop_op),
    .pop             (pop),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .frame_ok        (frame_ok),
    .is_range_report (is_range_report),
    .message_id      (message_id),
    .time_stamp_ms   (time_stamp_ms),
    .range_mm        (range_mm),
    .tof_signal      (tof_signal),
    .tof_accuracy    (tof_accuracy),
    .tof_state       (tof_state),
    .flow_speed_x    (flow_speed_x),
    .flow_speed_y    (flow_speed_y),
    .flow_confidence (flow_confidence),
    .flow_state      (flow_state)
  );

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int STALL_LIMIT = 2000;
  localparam int BYTE_TARGET = 1650;
  localparam int IDLE_TAIL = 10;
  localparam int MAX_REPORTS = 40;
  localparam logic [rffp_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = rffp_pkg::CFG_INDEX_W'(2);
  localparam logic [rffp_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI = '1;

  typedef enum logic [2:0] {
    PH_HUNT, PH_DEV_ID, PH_SYS_ID, PH_MSG_ID, PH_SEQ, PH_LEN, PH_PAYLOAD, PH_CHECK
  } phase_e;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SIGN} fill_e;

  typedef struct {
    logic               frame_ok;
    logic               is_range_report;
    logic [7:0]         message_id;
    logic [31:0]        time_stamp_ms;
    logic [31:0]        range_mm;
    logic [7:0]         tof_signal;
    logic [7:0]         tof_accuracy;
    logic [7:0]         tof_state;
    logic signed [15:0] flow_speed_x;
    logic signed [15:0] flow_speed_y;
    logic [7:0]         flow_confidence;
    logic [7:0]         flow_state;
  } report_t;

  class frame_checker;
    logic [7:0] header;
    logic [7:0] range_id;
    phase_e     phase;
    logic [7:0] sum;
    logic [7:0] msg_id;
    logic [7:0] len;
    logic [7:0] count;
    logic [7:0] store [rffp_pkg::MAX_PAYLOAD];
    report_t    expected_reports [$];
    int         errors;

    function new();
      header = rffp_pkg::HEADER_BYTE_RESET;
      range_id = rffp_pkg::RANGE_MSG_ID_RESET;
      phase = PH_HUNT;
      sum = '0;
      msg_id = '0;
      len = '0;
      count = '0;
      foreach (store[i]) store[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [rffp_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
      if (idx == rffp_pkg::REG_HEADER_BYTE) header = val;
      else if (idx == rffp_pkg::REG_RANGE_MSG_ID) range_id = val;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // advance the frame state by one accepted byte
    function void note_byte(logic [7:0] b);
      report_t r;
      case (phase)
        PH_HUNT: begin
          if (b == header) begin
            sum = b;
            phase = PH_DEV_ID;
          end
        end
        PH_DEV_ID, PH_SYS_ID, PH_SEQ: begin
          sum = sum + b;
          phase = phase_e'(phase + 3'd1);
        end
        PH_MSG_ID: begin
          sum = sum + b;
          msg_id = b;
          phase = PH_SEQ;
        end
        PH_LEN: begin
          sum = sum + b;
          len = b;
          count = '0;
          if (b == 0) phase = PH_CHECK;
          else if (b > rffp_pkg::MAX_PAYLOAD) phase = PH_HUNT;
          else phase = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum = sum + b;
          if (count < rffp_pkg::MAX_PAYLOAD) store[count] = b;
          count = count + 8'd1;
          if (count >= len) phase = PH_CHECK;
        end
        default: begin
          phase = PH_HUNT;
          count = '0;
          r.frame_ok = (b == sum);
          r.is_range_report = (msg_id == range_id);
          r.message_id = msg_id;
          r.time_stamp_ms = {store[3], store[2], store[1], store[0]};
          r.range_mm = {store[7], store[6], store[5], store[4]};
          r.tof_signal = store[8];
          r.tof_accuracy = store[9];
          r.tof_state = store[10];
          r.flow_speed_x = {store[13], store[12]};
          r.flow_speed_y = {store[15], store[14]};
          r.flow_confidence = store[16];
          r.flow_state = store[17];
          expected_reports.push_back(r);
        end
      endcase
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("%s: expected %0h, got %0h", name, e, a);
      end
    endfunction

    function void check_result(report_t got);
      report_t e;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("result with no finished frame pending");
        return;
      end
      e = expected_reports.pop_front();
      cmp("frame_ok", 32'(e.frame_ok), 32'(got.frame_ok));
      cmp("is_range_report", 32'(e.is_range_report), 32'(got.is_range_report));
      cmp("message_id", 32'(e.message_id), 32'(got.message_id));
      cmp("time_stamp_ms", e.time_stamp_ms, got.time_stamp_ms);
      cmp("range_mm", e.range_mm, got.range_mm);
      cmp("tof_signal", 32'(e.tof_signal), 32'(got.tof_signal));
      cmp("tof_accuracy", 32'(e.tof_accuracy), 32'(got.tof_accuracy));
      cmp("tof_state", 32'(e.tof_state), 32'(got.tof_state));
      cmp("flow_speed_x", 32'($unsigned(e.flow_speed_x)), 32'($unsigned(got.flow_speed_x)));
      cmp("flow_speed_y", 32'($unsigned(e.flow_speed_y)), 32'($unsigned(got.flow_speed_y)));
      cmp("flow_confidence", 32'(e.flow_confidence), 32'(got.flow_confidence));
      cmp("flow_state", 32'(e.flow_state), 32'(got.flow_state));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_ready;
  logic [7:0] rx_byte = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rffp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic frame_ok;
  logic is_range_report;
  logic [7:0] message_id;
  logic [31:0] time_stamp_ms;
  logic [31:0] range_mm;
  logic [7:0] tof_signal;
  logic [7:0] tof_accuracy;
  logic [7:0] tof_state;
  logic signed [15:0] flow_speed_x;
  logic signed [15:0] flow_speed_y;
  logic [7:0] flow_confidence;
  logic [7:0] flow_state;

  frame_checker sb = new();
  int bytes_sent = 0;
  bit tx_burst = 1'b0;
  int ready_hold = 0;
  int idle_cycles = 0;

  range_flow_frame_parser uut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_ready(rx_ready),
    .rx_byte(rx_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .frame_ok(frame_ok),
    .is_range_report(is_range_report),
    .message_id(message_id),
    .time_stamp_ms(time_stamp_ms),
    .range_mm(range_mm),
    .tof_signal(tof_signal),
    .tof_accuracy(tof_accuracy),
    .tof_state(tof_state),
    .flow_speed_x(flow_speed_x),
    .flow_speed_y(flow_speed_y),
    .flow_confidence(flow_confidence),
    .flow_state(flow_state)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side backpressure: mostly ready, with short and occasional long stalls
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        res_ready <= 1'b1;
        ready_hold <= $urandom_range(1, 30);
      end else if (r < 85) begin
        res_ready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else if (r < 95) begin
        res_ready <= 1'b0;
        ready_hold <= $urandom_range(3, 11);
      end else begin
        res_ready <= 1'b0;
        ready_hold <= $urandom_range(30, 80);
      end
    end
  end

  always @(posedge clk) begin
    report_t got;
    if (!rst && res_valid && res_ready) begin
      got.frame_ok = frame_ok;
      got.is_range_report = is_range_report;
      got.message_id = message_id;
      got.time_stamp_ms = time_stamp_ms;
      got.range_mm = range_mm;
      got.tof_signal = tof_signal;
      got.tof_accuracy = tof_accuracy;
      got.tof_state = tof_state;
      got.flow_speed_x = flow_speed_x;
      got.flow_speed_y = flow_speed_y;
      got.flow_confidence = flow_confidence;
      got.flow_state = flow_state;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (cfg_valid && cfg_ready) ||
        (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // valid stays high across back to back transfers
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!rx_ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained(input int tail);
    rx_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rffp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] hdr, input logic [7:0] rid, input bit junk);
    wait_drained(IDLE_TAIL);
    if (junk) begin
      write_reg(REG_UNUSED_LO, 8'($urandom), 1'b0);
      write_reg(REG_UNUSED_HI, 8'($urandom), 1'b0);
    end
    write_reg(rffp_pkg::REG_HEADER_BYTE, hdr, 1'b0);
    write_reg(rffp_pkg::REG_RANGE_MSG_ID, rid, 1'b1);
  endtask

  task automatic send_frame(input logic [7:0] msg, input logic [7:0] len,
                            input bit ck_good, input fill_e fill);
    logic [7:0] sum;
    logic [7:0] b;
    sum = sb.header;
    send_byte(sb.header);
    b = 8'($urandom);
    sum += b;
    send_byte(b);
    b = 8'($urandom);
    sum += b;
    send_byte(b);
    sum += msg;
    send_byte(msg);
    b = 8'($urandom);
    sum += b;
    send_byte(b);
    sum += len;
    send_byte(len);
    // oversized length drops the frame, nothing more to send
    if (len > rffp_pkg::MAX_PAYLOAD) return;
    for (int n = 0; n < len; n++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hff;
        FILL_SIGN: b = n[0] ? 8'h80 : 8'h7f;
        default:   b = 8'($urandom);
      endcase
      sum += b;
      send_byte(b);
    end
    if (ck_good) send_byte(sum);
    else send_byte(sum ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic random_frame();
    int r;
    logic [7:0] msg;
    logic [7:0] len;
    r = $urandom_range(0, 99);
    tx_burst = ($urandom_range(0, 3) == 0);
    if (r < 6) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (r < 10) begin
      // truncated frame, the following bytes land in the middle of it
      send_byte(sb.header);
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (r < 15) begin
      send_frame(8'($urandom), 8'($urandom_range(rffp_pkg::MAX_PAYLOAD + 1, 255)), 1'b1,
                 FILL_RANDOM);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) len = 8'($urandom_range(18, 20));
      else if (r < 60) len = 8'($urandom_range(0, 3));
      else if (r < 80) len = 8'($urandom_range(0, rffp_pkg::MAX_PAYLOAD));
      else len = 8'(rffp_pkg::MAX_PAYLOAD);
      msg = ($urandom_range(0, 99) < 60) ? sb.range_id : 8'($urandom);
      send_frame(msg, len, $urandom_range(0, 99) < 85, FILL_RANDOM);
    end
  endtask

  initial begin
    int quota;
    int frames;
    int pause_at;
    logic [7:0] hdr;
    logic [7:0] rid;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings first, store still zero
    send_frame(rffp_pkg::RANGE_MSG_ID_RESET, 8'd0, 1'b1, FILL_RANDOM);
    send_frame(rffp_pkg::RANGE_MSG_ID_RESET, 8'd18, 1'b1, FILL_ONES);
    send_frame(8'h00, 8'd18, 1'b0, FILL_ZERO);
    send_frame(8'hff, 8'd1, 1'b1, FILL_RANDOM);
    send_byte(8'h00);
    send_byte(8'h55);
    send_frame(8'h12, 8'd33, 1'b1, FILL_RANDOM);
    send_frame(8'h34, 8'd255, 1'b1, FILL_RANDOM);
    send_frame(rffp_pkg::RANGE_MSG_ID_RESET, 8'd32, 1'b1, FILL_SIGN);
    apply_config(8'h00, 8'hff, 1'b1);
    send_frame(8'hff, 8'd2, 1'b1, FILL_ONES);
    apply_config(8'hff, 8'h00, 1'b0);
    send_frame(8'h00, 8'd18, 1'b0, FILL_RANDOM);

    for (int p = 0; bytes_sent < BYTE_TARGET; p++) begin
      case (p % 4)
        0: begin
          hdr = rffp_pkg::HEADER_BYTE_RESET;
          rid = rffp_pkg::RANGE_MSG_ID_RESET;
        end
        1: begin
          hdr = 8'h00;
          rid = 8'h00;
        end
        2: begin
          hdr = 8'hff;
          rid = 8'hff;
        end
        default: begin
          hdr = 8'($urandom);
          rid = 8'($urandom);
        end
      endcase
      apply_config(hdr, rid, (p % 3) == 0);
      quota = bytes_sent + 200;
      if (quota > BYTE_TARGET) quota = BYTE_TARGET;
      pause_at = $urandom_range(1, 6);
      frames = 0;
      while (bytes_sent < quota) begin
        random_frame();
        frames++;
        // hold the sender until all results are out
        if (frames == pause_at) wait_drained(0);
      end
    end

    tx_burst = 1'b0;
    wait_drained(IDLE_TAIL);
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
